@@ rtl/assert_macros.svh @@
// Assertion macros shared by the escape sequence segmenter modules.
// Each macro expects signals named clock and reset in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/esc_seg_pkg.sv @@
// Types and byte constants shared by the escape sequence segmenter modules.
// No dependencies.
package esc_seg_pkg;

   typedef enum logic [1:0] {
      KIND_PLAIN    = 2'd0,
      KIND_SEQ      = 2'd1,
      KIND_UNKNOWN  = 2'd2,
      KIND_OVERFLOW = 2'd3
   } kind_type;

   localparam logic [7:0] ESC_BYTE       = 8'h1B;
   localparam logic [7:0] BEL_BYTE       = 8'h07;
   localparam logic [7:0] CSI_FINAL_LOW  = 8'h40;
   localparam logic [7:0] CSI_FINAL_HIGH = 8'h7E;
   localparam logic [7:0] CSI_OPEN       = 8'h5B;
   localparam logic [7:0] OSC_OPEN       = 8'h5D;
   localparam logic [7:0] BACKSLASH      = 8'h5C;

   typedef struct packed {
      logic is_esc;
      logic is_csi_open;
      logic is_osc_open;
      logic is_one_more;
      logic is_two_byte;
      logic is_csi_final;
      logic is_bel;
      logic osc_st;
      logic full_next;
      logic flush_last;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic     start;
      logic     push;
      logic     emit_plain;
      logic     emit_flush;
      logic     rd_clear;
      logic     next_rd;
      logic     end_flush;
      kind_type kind;
   } cmd_type;

endpackage

@@ rtl/esc_seg_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module esc_seg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/esc_seg_datapath.sv @@
// Datapath of the escape sequence segmenter: buffer RAM, fill count, read pointer,
// byte classification and the output register. Uses esc_seg_pkg and esc_seg_ram.
`include "assert_macros.svh"
module esc_seg_datapath
   import esc_seg_pkg::*;
#(
   parameter int SEQ_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_tdata,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic [1:0] rsp_tuser,
   output logic       rsp_tlast
);

   localparam int CW = $clog2(SEQ_DEPTH + 1);
   localparam int AW = $clog2(SEQ_DEPTH);

   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic          prev_esc_ff, prev_esc_in;
   kind_type      kind_ff, kind_in;
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_byte_ff, out_byte_in;
   kind_type      out_kind_ff, out_kind_in;
   logic          out_last_ff, out_last_in;
   logic [7:0]    rd_data;
   logic [AW-1:0] wr_addr;
   logic          wr_en;

   assign wr_en   = cmd.start || cmd.push;
   assign wr_addr = cmd.start ? '0 : count_ff[AW-1:0];

   esc_seg_ram #(.WIDTH(8), .DEPTH(SEQ_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_tdata),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      status.is_esc       = (req_tdata == ESC_BYTE);
      status.is_csi_open  = (req_tdata == CSI_OPEN);
      status.is_osc_open  = (req_tdata == OSC_OPEN);
      status.is_one_more  = (req_tdata == 8'h20) || (req_tdata == 8'h28) ||
                            (req_tdata == 8'h29) || (req_tdata == 8'h2A) ||
                            (req_tdata == 8'h2B) || (req_tdata == 8'h23) ||
                            (req_tdata == 8'h25);
      status.is_two_byte  = ((req_tdata >= 8'h30) && (req_tdata <= 8'h39)) ||
                            (req_tdata == 8'h44) || (req_tdata == 8'h45) ||
                            (req_tdata == 8'h48) || (req_tdata == 8'h4D) ||
                            (req_tdata == 8'h4E) || (req_tdata == 8'h63) ||
                            (req_tdata == 8'h6C) || (req_tdata == 8'h6D) ||
                            (req_tdata == 8'h6E) || (req_tdata == 8'h72) ||
                            (req_tdata == 8'h74) || (req_tdata == 8'h3D) ||
                            (req_tdata == 8'h3E) || (req_tdata == 8'h3C);
      status.is_csi_final = (req_tdata >= CSI_FINAL_LOW) && (req_tdata <= CSI_FINAL_HIGH);
      status.is_bel       = (req_tdata == BEL_BYTE);
      status.osc_st       = prev_esc_ff && (count_ff >= CW'(2)) && (req_tdata == BACKSLASH);
      status.full_next    = ((count_ff + CW'(1)) == CW'(SEQ_DEPTH));
      status.flush_last   = ((CW'(rd_ptr_ff) + CW'(1)) == count_ff);
      status.out_free     = !out_valid_ff || rsp_tready;
   end

   always_comb begin
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      prev_esc_in  = prev_esc_ff;
      kind_in      = kind_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_byte_in  = out_byte_ff;
      out_kind_in  = out_kind_ff;
      out_last_in  = out_last_ff;
      if (cmd.start) begin
         count_in    = CW'(1);
         prev_esc_in = status.is_esc;
      end
      if (cmd.push) begin
         count_in    = count_ff + CW'(1);
         prev_esc_in = status.is_esc;
      end
      if (cmd.rd_clear) begin
         rd_ptr_in = '0;
         kind_in   = cmd.kind;
      end
      if (cmd.next_rd) begin
         rd_ptr_in = rd_ptr_ff + AW'(1);
      end
      if (cmd.end_flush) begin
         count_in = '0;
      end
      if (cmd.emit_plain) begin
         out_valid_in = 1'b1;
         out_byte_in  = req_tdata;
         out_kind_in  = KIND_PLAIN;
         out_last_in  = 1'b1;
      end
      if (cmd.emit_flush) begin
         out_valid_in = 1'b1;
         out_byte_in  = rd_data;
         out_kind_in  = kind_ff;
         out_last_in  = status.flush_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_ptr_ff    <= '0;
         prev_esc_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_ptr_ff    <= rd_ptr_in;
         prev_esc_ff  <= prev_esc_in;
         out_valid_ff <= out_valid_in;
      end
      kind_ff     <= kind_in;
      out_byte_ff <= out_byte_in;
      out_kind_ff <= out_kind_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

   `ASSERT_NOW(a_count_range, 1'b1, count_ff <= CW'(SEQ_DEPTH))
   `ASSERT_NOW(a_no_overwrite, cmd.emit_plain || cmd.emit_flush, !out_valid_ff || rsp_tready)
   `ASSERT_NOW(a_one_source, 1'b1, !(cmd.emit_plain && cmd.emit_flush))
   `ASSERT_NEXT(a_flush_clears, cmd.end_flush, count_ff == '0)

endmodule

@@ rtl/esc_seg_controller.sv @@
// Controller state machine of the escape sequence segmenter: parse modes and
// the buffer release sequence. Uses esc_seg_pkg.
module esc_seg_controller
   import esc_seg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_NORMAL   = 7'b0000001,
      ST_ESC      = 7'b0000010,
      ST_CSI      = 7'b0000100,
      ST_OSC      = 7'b0001000,
      ST_ONE_MORE = 7'b0010000,
      ST_READ     = 7'b0100000,
      ST_LOAD     = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      accepting;
   logic      fire;
   logic      done;
   kind_type  done_kind;
   state_type open_state;

   assign accepting  = (state_ff == ST_NORMAL) || (state_ff == ST_ESC) ||
                       (state_ff == ST_CSI) || (state_ff == ST_OSC) ||
                       (state_ff == ST_ONE_MORE);
   assign req_tready = accepting && status.out_free;
   assign fire       = req_tvalid && req_tready;

   always_comb begin
      done       = 1'b0;
      done_kind  = KIND_SEQ;
      open_state = state_ff;
      unique case (state_ff)
         ST_ESC: begin
            priority if (status.is_esc) begin
               done      = 1'b1;
               done_kind = KIND_UNKNOWN;
            end else if (status.is_csi_open) begin
               open_state = ST_CSI;
            end else if (status.is_osc_open) begin
               open_state = ST_OSC;
            end else if (status.is_one_more) begin
               open_state = ST_ONE_MORE;
            end else if (status.is_two_byte) begin
               done = 1'b1;
            end else begin
               done      = 1'b1;
               done_kind = KIND_UNKNOWN;
            end
         end
         ST_CSI:      done = status.is_csi_final;
         ST_OSC:      done = status.is_bel || status.osc_st;
         ST_ONE_MORE: done = 1'b1;
         default:     done = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.kind = KIND_SEQ;
      unique case (state_ff)
         ST_NORMAL: begin
            if (fire) begin
               if (status.is_esc) begin
                  cmd.start = 1'b1;
                  state_in  = ST_ESC;
               end else begin
                  cmd.emit_plain = 1'b1;
               end
            end
         end
         ST_ESC, ST_CSI, ST_OSC, ST_ONE_MORE: begin
            if (fire) begin
               cmd.push = 1'b1;
               priority if (done) begin
                  cmd.rd_clear = 1'b1;
                  cmd.kind     = done_kind;
                  state_in     = ST_READ;
               end else if (status.full_next) begin
                  cmd.rd_clear = 1'b1;
                  cmd.kind     = KIND_OVERFLOW;
                  state_in     = ST_READ;
               end else begin
                  state_in = open_state;
               end
            end
         end
         ST_READ: state_in = ST_LOAD;
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.emit_flush = 1'b1;
               if (status.flush_last) begin
                  cmd.end_flush = 1'b1;
                  state_in      = ST_NORMAL;
               end else begin
                  cmd.next_rd = 1'b1;
                  state_in    = ST_READ;
               end
            end
         end
         default: state_in = ST_NORMAL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_NORMAL;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/escape_sequence_segmenter.sv @@
// Escape sequence segmenter: groups terminal escape sequences and releases each one whole.
// Top level; instantiates esc_seg_controller and esc_seg_datapath, uses esc_seg_pkg.
//
// The req channel takes one terminal byte per transfer in req_tdata. The rsp channel
// gives one released byte per transfer: rsp_tdata holds the byte, rsp_tuser the run
// kind (plain, sequence, unknown escape, overflow) and rsp_tlast marks the last byte.
// A plain byte outside a sequence appears on rsp in the cycle after its transfer.
// An ESC and the bytes after it are buffered in a RAM of SEQ_DEPTH bytes and
// produce no output until the sequence ends, turns out unknown, or fills the buffer.
// The buffer is then released byte by byte, each byte going through the registered RAM
// read followed by the load of the output register; no input is taken meanwhile.
// Buffered bytes are taken as they arrive, plain bytes at one byte a cycle unless rsp stalls.
// A single output register sits between the channels: a new byte is taken while a
// result waits only if that result is taken in the same cycle. When the receiver stalls,
// the output holds and the block waits. Reset is synchronous and returns the block to
// normal mode with an empty buffer and no pending output.
module escape_sequence_segmenter
   import esc_seg_pkg::*;
#(
   parameter int SEQ_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] byte_in
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] byte_out
   output logic [1:0] rsp_tuser,   // [1:0] run_kind
   output logic       rsp_tlast
);

   status_type status;
   cmd_type    cmd;

   esc_seg_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   esc_seg_datapath #(.SEQ_DEPTH(SEQ_DEPTH)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
